@@ hdl/moving_average_filter_assert.svh @@
`ifndef MOVING_AVERAGE_FILTER_ASSERT_SVH
`define MOVING_AVERAGE_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving average filter check failed");

// Next-cycle implication, disabled during reset.
`define MAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving average filter check failed");

`endif

@@ hdl/maf_pkg.sv @@
package maf_pkg;

   localparam int MAX_WINDOW    = 32;
   localparam int SAMPLE_BITS   = 16;
   localparam int CFG_LEN_BITS  = 6;
   localparam int LEN_BITS      = $clog2(MAX_WINDOW + 1);
   localparam int POS_BITS      = $clog2(MAX_WINDOW);
   localparam int SUM_BITS      = SAMPLE_BITS + POS_BITS;
   localparam int DIV_STAGES    = SUM_BITS;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_WINDOW_LEN_ADDR = '0;

   localparam logic [CFG_LEN_BITS-1:0] WINDOW_LEN_RESET = CFG_LEN_BITS'(4);

   typedef struct packed {
      logic                       valid;
      logic signed [SUM_BITS-1:0] sum;
      logic [LEN_BITS-1:0]        div;
      logic                       avg;
   } ent_type;

   typedef struct packed {
      logic                valid;
      logic [SUM_BITS-1:0] work;
      logic [LEN_BITS-1:0] rem;
      logic [LEN_BITS-1:0] div;
      logic                neg;
      logic                avg;
   } tok_type;

endpackage

@@ hdl/moving_average_filter.sv @@
// An accepted item passes the entry register and then every division cell before its result is valid.
// Throughput: one item per cycle, set by the chain of division cells, one quotient bit per cell.
// A result that is not taken stalls the whole chain and the input together.
// Reset is synchronous: window_len returns to 4, the running sum and sample count clear,
// and every division cell is emptied.
`include "moving_average_filter_assert.svh"

module moving_average_filter (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [maf_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  logic                                      req_restart,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [maf_pkg::SAMPLE_BITS-1:0]    rsp_filtered,
   output logic                                      rsp_averaged,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [maf_pkg::CSR_ADDR_BITS-1:0]         csr_paddr,
   input  logic [maf_pkg::CSR_DATA_BITS-1:0]         csr_pwdata,
   output logic [maf_pkg::CSR_DATA_BITS-1:0]         csr_prdata,
   output logic                                      csr_pready
);

   logic [maf_pkg::CFG_LEN_BITS-1:0]   window_len_ff;
   logic [maf_pkg::LEN_BITS-1:0]       seen_count_ff;
   logic [maf_pkg::LEN_BITS-1:0]       seen_count_in;
   logic signed [maf_pkg::SUM_BITS-1:0] sum_ff;
   logic signed [maf_pkg::SUM_BITS-1:0] sum_in;
   maf_pkg::ent_type                   ent_ff;
   maf_pkg::ent_type                   ent_in;

   logic [maf_pkg::LEN_BITS-1:0]       len_eff;
   logic                               accept;
   logic                               cfg_write;
   logic                               advance;
   logic                               full_after;
   logic                               restart_take;
   logic signed [maf_pkg::SUM_BITS-1:0] sample_ext;
   logic signed [maf_pkg::SUM_BITS-1:0] neg_sum;
   logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_d [maf_pkg::MAX_WINDOW];
   logic signed [maf_pkg::SAMPLE_BITS-1:0] taps  [maf_pkg::MAX_WINDOW];
   maf_pkg::tok_type                   tok   [maf_pkg::DIV_STAGES+1];
   maf_pkg::tok_type                   last_tok;
   logic [maf_pkg::SAMPLE_BITS-1:0]    quot;

   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == maf_pkg::CSR_WINDOW_LEN_ADDR);
   assign csr_pready = 1'b1;
   assign csr_prdata = maf_pkg::CSR_DATA_BITS'(window_len_ff);

   assign advance   = !tok[maf_pkg::DIV_STAGES].valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (window_len_ff == '0) begin
         len_eff = maf_pkg::LEN_BITS'(1);
      end else if (int'(window_len_ff) > maf_pkg::MAX_WINDOW) begin
         len_eff = maf_pkg::LEN_BITS'(maf_pkg::MAX_WINDOW);
      end else begin
         len_eff = maf_pkg::LEN_BITS'(window_len_ff);
      end
   end

   // The delay line holds the previous samples, newest in the first cell.
   assign tap_d[0] = req_sample;

   genvar k;
   generate
      for (k = 0; k < maf_pkg::MAX_WINDOW; k++) begin : g_tap
         if (k > 0) begin : g_link
            assign tap_d[k] = taps[k-1];
         end
         maf_tap_cell u_tap (
            .clock    (clock),
            .shift_en (accept),
            .tap_d    (tap_d[k]),
            .tap_q    (taps[k])
         );
      end
   endgenerate

   assign sample_ext = maf_pkg::SUM_BITS'(req_sample);

   always_comb begin
      logic [maf_pkg::LEN_BITS-1:0]        count_base;
      logic signed [maf_pkg::SUM_BITS-1:0] sum_base;
      logic signed [maf_pkg::SUM_BITS-1:0] old_ext;
      logic [maf_pkg::POS_BITS-1:0]        old_pos;
      logic                                full_before;
      count_base  = req_restart ? '0 : seen_count_ff;
      sum_base    = req_restart ? '0 : sum_ff;
      old_pos     = maf_pkg::POS_BITS'(len_eff - maf_pkg::LEN_BITS'(1));
      old_ext     = maf_pkg::SUM_BITS'(taps[old_pos]);
      full_before = count_base >= len_eff;
      seen_count_in = full_before ? count_base : count_base + maf_pkg::LEN_BITS'(1);
      sum_in        = sum_base - (full_before ? old_ext : '0) + sample_ext;
      full_after    = seen_count_in >= len_eff;
      ent_in.valid  = accept;
      ent_in.sum    = full_after ? sum_in : sample_ext;
      ent_in.div    = full_after ? len_eff : maf_pkg::LEN_BITS'(1);
      ent_in.avg    = full_after;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= maf_pkg::WINDOW_LEN_RESET;
         seen_count_ff <= '0;
         sum_ff        <= '0;
         ent_ff.valid  <= 1'b0;
      end else begin
         if (cfg_write) begin
            window_len_ff <= csr_pwdata[maf_pkg::CFG_LEN_BITS-1:0];
            seen_count_ff <= '0;
            sum_ff        <= '0;
         end else if (accept) begin
            seen_count_ff <= seen_count_in;
            sum_ff        <= sum_in;
         end
         if (advance) begin
            ent_ff <= ent_in;
         end
      end
   end

   assign neg_sum = -ent_ff.sum;

   always_comb begin
      tok[0].valid = ent_ff.valid;
      tok[0].neg   = ent_ff.sum[maf_pkg::SUM_BITS-1];
      tok[0].work  = ent_ff.sum[maf_pkg::SUM_BITS-1] ? neg_sum : ent_ff.sum;
      tok[0].rem   = '0;
      tok[0].div   = ent_ff.div;
      tok[0].avg   = ent_ff.avg;
   end

   genvar d;
   generate
      for (d = 0; d < maf_pkg::DIV_STAGES; d++) begin : g_div
         maf_div_cell u_div (
            .clock   (clock),
            .reset   (reset),
            .advance (advance),
            .up_tok  (tok[d]),
            .dn_tok  (tok[d+1])
         );
      end
   endgenerate

   assign last_tok     = tok[maf_pkg::DIV_STAGES];
   assign quot         = tok[maf_pkg::DIV_STAGES].work[maf_pkg::SAMPLE_BITS-1:0];
   assign rsp_valid    = tok[maf_pkg::DIV_STAGES].valid;
   assign rsp_filtered = tok[maf_pkg::DIV_STAGES].neg ? -quot : quot;
   assign rsp_averaged = tok[maf_pkg::DIV_STAGES].avg;

   assign restart_take = accept && req_restart && !cfg_write;

   `MAF_ASSERT_IMP(a_count_in_window, clock, reset, 1'b1, seen_count_ff <= len_eff)
   `MAF_ASSERT_NEXT(a_accept_enters, clock, reset, accept && !cfg_write, ent_ff.valid)
   `MAF_ASSERT_NEXT(a_restart_first, clock, reset, restart_take, seen_count_ff == 6'(1))
   `MAF_ASSERT_IMP(a_rem_below_div, clock, reset, last_tok.valid, last_tok.rem < last_tok.div)

endmodule

@@ hdl/maf_tap_cell.sv @@
module maf_tap_cell (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_d,
   output logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_q
);

   logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_ff;
   logic signed [maf_pkg::SAMPLE_BITS-1:0] tap_in;

   assign tap_in = shift_en ? tap_d : tap_ff;

   always_ff @(posedge clock) begin
      tap_ff <= tap_in;
   end

   assign tap_q = tap_ff;

endmodule

@@ hdl/maf_div_cell.sv @@
module maf_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  maf_pkg::tok_type up_tok,
   output maf_pkg::tok_type dn_tok
);

   maf_pkg::tok_type tok_ff;
   maf_pkg::tok_type tok_in;

   // One restoring division step: bring down the next dividend bit and
   // subtract the divisor where it fits.
   always_comb begin
      logic [maf_pkg::LEN_BITS:0] rem_sh;
      logic [maf_pkg::LEN_BITS:0] diff;
      logic                       fits;
      rem_sh = {up_tok.rem, up_tok.work[maf_pkg::SUM_BITS-1]};
      diff   = rem_sh - {1'b0, up_tok.div};
      fits   = rem_sh >= {1'b0, up_tok.div};
      tok_in      = up_tok;
      tok_in.work = {up_tok.work[maf_pkg::SUM_BITS-2:0], fits};
      tok_in.rem  = fits ? diff[maf_pkg::LEN_BITS-1:0] : rem_sh[maf_pkg::LEN_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign dn_tok = tok_ff;

endmodule

@@ tb/moving_average_filter_checker.sv @@
`timescale 1ns / 1ps

module moving_average_filter_checker
   import maf_pkg::*;
#(
   parameter logic [CSR_ADDR_BITS-1:0] WINDOW_LEN_ADDR = CSR_WINDOW_LEN_ADDR
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [SAMPLE_BITS-1:0] rsp_filtered,
   input  logic                          rsp_averaged,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]      csr_pwdata,
   input  logic                          csr_pready,
   output int                            mismatches,
   output int                            pending
);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          averaged;
   } filter_result_type;

   logic signed [SAMPLE_BITS-1:0] delay_line [MAX_WINDOW];
   logic signed [SUM_BITS-1:0]    running_sum;
   logic [LEN_BITS-1:0]           fill_count;
   logic [POS_BITS-1:0]           head;
   logic [CFG_LEN_BITS-1:0]       len_setting;
   filter_result_type             expected_results [$];
   int                            mismatch_count = 0;
   int                            outstanding = 0;

   assign mismatches = mismatch_count;
   assign pending    = outstanding;

   function automatic void clear_history();
      for (int i = 0; i < MAX_WINDOW; i++) begin
         delay_line[i] = '0;
      end
      running_sum = '0;
      fill_count  = '0;
      head        = '0;
   endfunction

   function automatic filter_result_type filter_sample(
      input logic signed [SAMPLE_BITS-1:0] s,
      input logic restart);
      int                  span;
      logic [POS_BITS-1:0] oldest;
      filter_result_type   r;
      if (len_setting == 0) begin
         span = 1;
      end else if (len_setting > MAX_WINDOW) begin
         span = MAX_WINDOW;
      end else begin
         span = int'(len_setting);
      end
      if (restart) begin
         clear_history();
      end
      if (fill_count >= span) begin
         oldest = head - POS_BITS'(span);
         running_sum = running_sum - delay_line[oldest];
      end else begin
         fill_count = fill_count + 1'b1;
      end
      running_sum = running_sum + s;
      delay_line[head] = s;
      head = head + 1'b1;
      if (fill_count >= span) begin
         r.filtered = SAMPLE_BITS'(int'(running_sum) / span);
         r.averaged = 1'b1;
      end else begin
         r.filtered = s;
         r.averaged = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, text);
      end
   endtask

   always @(posedge clock) begin
      filter_result_type want;
      if (reset) begin
         clear_history();
         len_setting = WINDOW_LEN_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result: filtered %0d averaged %0b",
                                         rsp_filtered, rsp_averaged));
            end else begin
               want = expected_results.pop_front();
               if (want.filtered !== rsp_filtered || want.averaged !== rsp_averaged) begin
                  report_mismatch($sformatf(
                     "result mismatch: expected filtered %0d averaged %0b, got %0d %0b",
                     want.filtered, want.averaged, rsp_filtered, rsp_averaged));
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == WINDOW_LEN_ADDR) begin
            len_setting = csr_pwdata[CFG_LEN_BITS-1:0];
            clear_history();
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(filter_sample(req_sample, req_restart));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

@@ tb/moving_average_filter_tb.sv @@
`timescale 1ns / 1ps

module moving_average_filter_tb;
   import maf_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0]  WINDOW_LEN_ADDR = CSR_WINDOW_LEN_ADDR;
   localparam int                        CYCLE_LIMIT     = 400000;
   localparam int                        SETTLE_CYCLES   = 2 * (1 + SUM_BITS) + 10;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample   = '0;
   logic                          req_restart  = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready    = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered;
   logic                          rsp_averaged;
   logic                          csr_psel     = 1'b0;
   logic                          csr_penable  = 1'b0;
   logic                          csr_pwrite   = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      csr_paddr    = '0;
   logic [CSR_DATA_BITS-1:0]      csr_pwdata   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_prdata;
   logic                          csr_pready;
   int                            mismatches;
   int                            pending;
   int                            cycle_count  = 0;
   logic [8:0]                    stall_phase  = '0;

   moving_average_filter dut (.*);

   moving_average_filter_checker #(.WINDOW_LEN_ADDR(WINDOW_LEN_ADDR)) u_checker (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("moving_average_filter_tb NOT OK");
         $finish;
      end
   end

   // The receiver cycles through always ready, coin-toss, sparse and long stall stretches.
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[8:7])
         2'd0: rsp_ready <= 1'b1;
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= stall_phase[4];
      endcase
   end

   task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value,
                              input logic restart);
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_window_len(input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WINDOW_LEN_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      int near_zero;
      near_zero = $urandom_range(0, 16);
      case ($urandom_range(0, 9))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2, 3: return SAMPLE_BITS'(near_zero - 8);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   task automatic stream_samples(input int count, input int max_gap, input int restart_pct);
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < count; i++) begin
         push_sample(pick_sample(), $urandom_range(0, 99) < restart_pct);
         burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   initial begin
      int settings [12];
      int chosen;
      settings = '{32, 33, 63, 1, 2, 3, 31, 17, 5, 0, 4, 0};
      settings[10] = $urandom_range(1, 32);
      settings[11] = $urandom_range(0, 63);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset window of four: full-scale steps, then truncation toward zero after a restart.
      repeat (4) push_sample(SAMPLE_MAX, 1'b0);
      repeat (4) push_sample(SAMPLE_MIN, 1'b0);
      push_sample(-16'sd1, 1'b1);
      repeat (3) push_sample(16'sd0, 1'b0);
      push_sample(-16'sd7, 1'b0);
      push_sample(16'sd6, 1'b0);
      push_sample(16'sd100, 1'b1);

      await_results();
      write_window_len(32'd0);
      push_sample(16'sd12345, 1'b0);
      push_sample(SAMPLE_MIN, 1'b0);
      push_sample(-16'sd3, 1'b0);

      await_results();
      write_window_len(32'd2);
      push_sample(SAMPLE_MIN, 1'b0);
      push_sample(-16'sd32767, 1'b0);
      push_sample(SAMPLE_MAX, 1'b0);

      foreach (settings[p]) begin
         await_results();
         chosen = settings[p];
         write_window_len(($urandom() & ~32'h3F) | CSR_DATA_BITS'(chosen));
         stream_samples(90, (p % 3 == 0) ? 0 : 6, 2);
         if (p == 4) begin
            await_results();
            stream_samples(40, 3, 5);
         end
      end

      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("moving_average_filter_tb OK");
      end else begin
         $display("moving_average_filter_tb NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/maf_pkg.sv
hdl/maf_tap_cell.sv
hdl/maf_div_cell.sv
hdl/moving_average_filter.sv
tb/moving_average_filter_checker.sv
tb/moving_average_filter_tb.sv
